// ----- rtl/aabb_pkg.sv -----
package aabb_pkg;

   localparam int COORD_BITS = 32;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int DEPTH_BITS = COORD_BITS - 1;
   localparam int CNT_BITS   = 8;

   localparam logic [CNT_BITS-1:0] MAX_CONTACTS_RESET = CNT_BITS'(4);
   localparam logic [CNT_BITS-1:0] CONTACTS_PER_PAIR  = CNT_BITS'(4);

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_INTER = 2'd1;
   localparam logic [1:0] STATUS_FAIL     = 2'd2;
   localparam logic [1:0] STATUS_MAX_CONT = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic [DEPTH_BITS-1:0]        depth_type;

   typedef struct packed {
      coord_type a_min_x;
      coord_type a_min_y;
      coord_type a_min_z;
      coord_type a_max_x;
      coord_type a_max_y;
      coord_type a_max_z;
      coord_type b_min_x;
      coord_type b_min_y;
      coord_type b_min_z;
      coord_type b_max_x;
      coord_type b_max_y;
      coord_type b_max_z;
   } req_type;

   typedef struct packed {
      coord_type  contact_x;
      coord_type  contact_y;
      coord_type  contact_z;
      logic [1:0] normal_axis;
      logic       normal_negative;
      depth_type  depth;
      logic       contact_valid;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

// ----- rtl/aabb_pair_contact_generator_core.sv -----
// Channel  | Ports                            | Payload
// request  | req_valid, req_stall, req_data   | box A and box B corners
// response | rsp_valid, rsp_stall, rsp_data   | one contact or one status result
// csr      | csr_wr_en, csr_wr_data           | max_contacts (write clears used count)
//
// A box pair gives as many results as it needs: 1 for a status-only answer,
// 1 to 4 for contacts. The one response register sends a result per cycle while rsp_stall is low.
// The first result passes through the request register and then the response register.
// The request register takes the next pair while the current one is still sending.
// A stalled result holds; req_stall rises only while both registers are occupied.
// Synchronous active-high reset; max_contacts resets to 4, used count to 0.
module aabb_pair_contact_generator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  aabb_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output aabb_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [aabb_pkg::CNT_BITS-1:0]        csr_wr_data
);
   import aabb_pkg::*;

   typedef struct packed {
      logic       contact;     // 0: status-only result
      logic [1:0] status;      // status of a status-only result
      logic [1:0] last_k;      // index of the final contact
      logic       short_pkt;   // slots ran out: final contact carries max_contacts
      logic [1:0] axis;
      logic       neg;
      depth_type  depth;
      coord_type  face;
      coord_type  lo_u;
      coord_type  hi_u;
      coord_type  lo_v;
      coord_type  hi_v;
   } pkt_type;

   req_type                in_ff, in_in;
   logic                   in_vld_ff, in_vld_in;
   pkt_type                pkt_ff, pkt_in;
   logic                   pkt_vld_ff, pkt_vld_in;
   logic [1:0]             k_ff, k_in;
   logic [CNT_BITS-1:0]    max_ff, max_in;
   logic [CNT_BITS-1:0]    used_ff, used_in;

   logic                   req_take, rsp_take, pkt_done, pkt_load;
   logic [2:0]             keep_n;

   coord_type              amin [3];
   coord_type              amax [3];
   coord_type              bmin [3];
   coord_type              bmax [3];
   coord_type              lo   [3];
   coord_type              hi   [3];
   diff_type               pen  [3];
   logic [2:0]             pos;
   logic                   apart;
   logic [1:0]             axis;
   diff_type               pen_sel;
   logic [CNT_BITS-1:0]    avail;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign pkt_done = rsp_take && (k_ff == pkt_ff.last_k);
   assign pkt_load = in_vld_ff && (!pkt_vld_ff || pkt_done);
   assign req_stall = in_vld_ff && !pkt_load;
   assign rsp_valid = pkt_vld_ff;

   // per-axis overlap: pen = min(b_max - a_min, a_max - b_min) is the negated max(f, g)
   always_comb begin
      diff_type h1, h2;
      amin[0] = in_ff.a_min_x; amin[1] = in_ff.a_min_y; amin[2] = in_ff.a_min_z;
      amax[0] = in_ff.a_max_x; amax[1] = in_ff.a_max_y; amax[2] = in_ff.a_max_z;
      bmin[0] = in_ff.b_min_x; bmin[1] = in_ff.b_min_y; bmin[2] = in_ff.b_min_z;
      bmax[0] = in_ff.b_max_x; bmax[1] = in_ff.b_max_y; bmax[2] = in_ff.b_max_z;
      apart = 1'b0;
      for (int a = 0; a < 3; a++) begin
         h1 = DIFF_BITS'(bmax[a]) - DIFF_BITS'(amin[a]);
         h2 = DIFF_BITS'(amax[a]) - DIFF_BITS'(bmin[a]);
         if (h1 <= 0 || h2 <= 0) begin
            apart = 1'b1;
         end
         pos[a] = h1 < h2;
         pen[a] = pos[a] ? h1 : h2;
         lo[a]  = (amin[a] > bmin[a]) ? amin[a] : bmin[a];
         hi[a]  = (amax[a] < bmax[a]) ? amax[a] : bmax[a];
      end
   end

   // least penetration wins; ties go to y, z only if strictly smaller
   always_comb begin
      logic [1:0] xy;
      xy = (pen[0] < pen[1]) ? AXIS_X : AXIS_Y;
      axis = (pen[2] < pen[xy]) ? AXIS_Z : xy;
      pen_sel = pen[axis];
   end

   assign avail = max_ff - used_ff;

   always_comb begin
      pkt_in = '0;
      keep_n = 3'd0;
      pkt_in.axis  = axis;
      pkt_in.neg   = !pos[axis];
      pkt_in.depth = (pen_sel[DIFF_BITS-1:DEPTH_BITS] != '0) ? '1 : pen_sel[DEPTH_BITS-1:0];
      pkt_in.face  = pos[axis] ? bmax[axis] : bmin[axis];
      unique case (axis)
         AXIS_X: begin
            pkt_in.lo_u = lo[2]; pkt_in.hi_u = hi[2];
            pkt_in.lo_v = lo[1]; pkt_in.hi_v = hi[1];
         end
         AXIS_Y: begin
            pkt_in.lo_u = lo[0]; pkt_in.hi_u = hi[0];
            pkt_in.lo_v = lo[2]; pkt_in.hi_v = hi[2];
         end
         default: begin
            pkt_in.lo_u = lo[1]; pkt_in.hi_u = hi[1];
            pkt_in.lo_v = lo[0]; pkt_in.hi_v = hi[0];
         end
      endcase
      priority if (max_ff == '0) begin
         pkt_in.status = STATUS_FAIL;
      end else if (apart) begin
         pkt_in.status = STATUS_NO_INTER;
      end else if (used_ff >= max_ff) begin
         pkt_in.status = STATUS_FAIL;
      end else begin
         pkt_in.contact   = 1'b1;
         pkt_in.status    = STATUS_OK;
         pkt_in.short_pkt = avail < CONTACTS_PER_PAIR;
         keep_n = pkt_in.short_pkt ? avail[2:0] : CONTACTS_PER_PAIR[2:0];
         pkt_in.last_k = 2'(keep_n - 3'd1);
      end
   end

   always_comb begin
      in_in      = req_take ? req_data : in_ff;
      in_vld_in  = req_take || (in_vld_ff && !pkt_load);
      pkt_vld_in = pkt_load || (pkt_vld_ff && !pkt_done);
      k_in       = k_ff;
      if (pkt_load) begin
         k_in = 2'd0;
      end else if (rsp_take) begin
         k_in = k_ff + 2'd1;
      end
      max_in  = max_ff;
      used_in = used_ff;
      if (csr_wr_en) begin
         max_in  = csr_wr_data;
         used_in = '0;
      end else if (pkt_load) begin
         used_in = used_ff + CNT_BITS'(keep_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         pkt_vld_ff <= 1'b0;
         k_ff       <= 2'd0;
         max_ff     <= MAX_CONTACTS_RESET;
         used_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         pkt_vld_ff <= pkt_vld_in;
         k_ff       <= k_in;
         max_ff     <= max_in;
         used_ff    <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (pkt_load) begin
         pkt_ff <= pkt_in;
      end
   end

   // result mux: corner order (u lo, v lo), (u lo, v hi), (u hi, v lo), (u hi, v hi)
   always_comb begin
      coord_type pu, pv;
      logic      at_end;
      pu = k_ff[1] ? pkt_ff.hi_u : pkt_ff.lo_u;
      pv = k_ff[0] ? pkt_ff.hi_v : pkt_ff.lo_v;
      at_end = k_ff == pkt_ff.last_k;
      rsp_data = '0;
      rsp_data.last = 1'b1;
      rsp_data.status = pkt_ff.status;
      if (pkt_ff.contact) begin
         rsp_data.contact_valid   = 1'b1;
         rsp_data.normal_axis     = pkt_ff.axis;
         rsp_data.normal_negative = pkt_ff.neg;
         rsp_data.depth           = pkt_ff.depth;
         rsp_data.last            = at_end;
         rsp_data.status = (at_end && pkt_ff.short_pkt) ? STATUS_MAX_CONT : STATUS_OK;
         unique case (pkt_ff.axis)
            AXIS_X: begin
               rsp_data.contact_x = pkt_ff.face;
               rsp_data.contact_y = pv;
               rsp_data.contact_z = pu;
            end
            AXIS_Y: begin
               rsp_data.contact_x = pu;
               rsp_data.contact_y = pkt_ff.face;
               rsp_data.contact_z = pv;
            end
            default: begin
               rsp_data.contact_x = pv;
               rsp_data.contact_y = pu;
               rsp_data.contact_z = pkt_ff.face;
            end
         endcase
      end
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= max_ff)
      else $error("contacts used exceeds slot limit");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      pkt_load && !csr_wr_en |=> used_ff == $past(used_ff) + CNT_BITS'($past(keep_n)))
      else $error("used count not advanced by kept contacts");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.contact_valid |-> rsp_data.last && pkt_ff.last_k == 2'd0)
      else $error("status-only result is not single and final");

   a_maxc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_MAX_CONT |-> rsp_data.last && rsp_data.contact_valid)
      else $error("max_contacts status on a non-final result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && pkt_vld_ff)
      else $error("request stalled with free space");

endmodule
